FILE: rtl/core/hmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmf_pkg
// Shared types and fixed widths for the Hausdorff match fraction block.
// ----------------------------------------------------------------------------
package hmf_pkg;

  localparam int FIELD_W   = 16;
  localparam int THR_W     = 16;
  localparam int LIMIT_W   = 2 * THR_W;
  localparam int CNT_OUT_W = 9;
  localparam int FRAC_W    = 17;
  localparam int DIV_CNT_W = 5;

  typedef enum logic [1:0] {
    ACT_CLEAR     = 2'd0,
    ACT_ADD_MODEL = 2'd1,
    ACT_ADD_IMAGE = 2'd2,
    ACT_EVALUATE  = 2'd3
  } hmf_action_t;

  typedef struct packed {
    hmf_action_t               action;
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
  } hmf_cmd_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] match_count;
    logic [CNT_OUT_W-1:0] model_size;
    logic [FRAC_W-1:0]    match_fraction;
    logic                 points_dropped;
  } hmf_result_t;

endpackage

FILE: rtl/core/hmf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/hausdorff_match_fraction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hausdorff_match_fraction
// Directed Hausdorff match fraction over a stored model and image point set.
// ----------------------------------------------------------------------------
// Commands are transferred at a rising edge with start high and busy low.
// Clear, add-model and add-image complete while busy stays low, so points
// load one per cycle. An add to a full set is dropped and flagged.
// Evaluate walks every model/image pair out of two point RAMs: for each model
// point one read of the model RAM, then the image RAM is streamed one entry a
// cycle through a subtract/square stage and a sum/compare stage. After the
// last model point, bit-serial division forms the fraction and done is
// registered from its final step. If either set is empty, done pulses in the
// cycle after the transfer. The image RAM read port sets the pace: one pair
// per cycle while the image points for one model point are streamed.
// Each result appears with a one-cycle done pulse and is held until the next;
// the receiver cannot stall it, and a new command may be taken in that cycle.
// The threshold is written through cfg_valid/cfg_ready, ready always high;
// write it only while idle. Reset empties both sets, clears the drop flag
// and the threshold. The point RAMs need no clearing pass.
// ----------------------------------------------------------------------------
module hausdorff_match_fraction #(
  parameter int MAX_MODEL_POINTS = 256,
  parameter int MAX_IMAGE_POINTS = 256,
  parameter int COORD_BITS       = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  hmf_pkg::hmf_cmd_t    cmd,
  output logic                 done,
  output hmf_pkg::hmf_result_t result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [hmf_pkg::THR_W-1:0] cfg_data
);

  import hmf_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int MAW   = (MAX_MODEL_POINTS > 1) ? $clog2(MAX_MODEL_POINTS) : 1;
  localparam int IAW   = (MAX_IMAGE_POINTS > 1) ? $clog2(MAX_IMAGE_POINTS) : 1;
  localparam int MFW   = $clog2(MAX_MODEL_POINTS + 1);
  localparam int IFW   = $clog2(MAX_IMAGE_POINTS + 1);
  localparam int SW    = 2 * C + 1;
  localparam int DW    = (SW > LIMIT_W) ? SW : LIMIT_W;
  localparam logic [MFW-1:0] MODEL_CAP = MFW'(MAX_MODEL_POINTS);
  localparam logic [IFW-1:0] IMAGE_CAP = IFW'(MAX_IMAGE_POINTS);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(FRAC_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MREAD,
    S_MLATCH,
    S_SCAN,
    S_DIV
  } state_t;

  state_t                 state;
  logic [THR_W-1:0]       match_threshold;
  logic [LIMIT_W-1:0]     limit;
  logic [MFW-1:0]         model_fill;
  logic [IFW-1:0]         image_fill;
  logic                   overflow_seen;
  logic [MFW-1:0]         mi;
  logic [IFW-1:0]         ij;
  logic [MFW-1:0]         count;
  logic                   hit;
  logic                   iss_v;
  logic                   sq_v;
  logic signed [C-1:0]    mx;
  logic signed [C-1:0]    my;
  logic [2*C-1:0]         sq_x;
  logic [2*C-1:0]         sq_y;
  logic [MFW:0]           rem;
  logic [FRAC_W-1:0]      quo;
  logic [DIV_CNT_W-1:0]   div_cnt;

  logic                   accept;
  logic signed [C-1:0]    cx;
  logic signed [C-1:0]    cy;
  logic                   model_we;
  logic                   image_we;
  logic [2*C-1:0]         model_rdata;
  logic [2*C-1:0]         image_rdata;
  logic signed [C-1:0]    ix;
  logic signed [C-1:0]    iy;
  logic [C:0]             dx;
  logic [C:0]             dy;
  logic [C:0]             ndx;
  logic [C:0]             ndy;
  logic [C-1:0]           ax;
  logic [C-1:0]           ay;
  logic [DW-1:0]          dsq;
  logic [MFW-1:0]         count_next;
  logic [MFW-1:0]         mi_next;
  logic [MFW:0]           trial;
  logic                   ge;
  logic [MFW:0]           rem_next;
  logic [FRAC_W-1:0]      quo_next;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign cx = C'($signed(cmd.point_x));
  assign cy = C'($signed(cmd.point_y));

  assign model_we = accept && (cmd.action == ACT_ADD_MODEL) && (model_fill < MODEL_CAP);
  assign image_we = accept && (cmd.action == ACT_ADD_IMAGE) && (image_fill < IMAGE_CAP);

  hmf_ram #(.WIDTH(2 * C), .DEPTH(MAX_MODEL_POINTS)) u_model_ram (
    .clk   (clk),
    .we    (model_we),
    .waddr (model_fill[MAW-1:0]),
    .wdata ({cx, cy}),
    .raddr (mi[MAW-1:0]),
    .rdata (model_rdata)
  );

  hmf_ram #(.WIDTH(2 * C), .DEPTH(MAX_IMAGE_POINTS)) u_image_ram (
    .clk   (clk),
    .we    (image_we),
    .waddr (image_fill[IAW-1:0]),
    .wdata ({cx, cy}),
    .raddr (ij[IAW-1:0]),
    .rdata (image_rdata)
  );

  assign ix  = image_rdata[2*C-1:C];
  assign iy  = image_rdata[C-1:0];
  assign dx  = {mx[C-1], mx} - {ix[C-1], ix};
  assign dy  = {my[C-1], my} - {iy[C-1], iy};
  assign ndx = -dx;
  assign ndy = -dy;
  assign ax  = dx[C] ? ndx[C-1:0] : dx[C-1:0];
  assign ay  = dy[C] ? ndy[C-1:0] : dy[C-1:0];

  assign dsq        = DW'(sq_x) + DW'(sq_y);
  assign count_next = count + MFW'(hit);
  assign mi_next    = mi + MFW'(1);

  assign trial    = (div_cnt == DIV_STEPS) ? rem : {rem[MFW-1:0], 1'b0};
  assign ge       = (trial >= {1'b0, model_fill});
  assign rem_next = ge ? (trial - {1'b0, model_fill}) : trial;
  assign quo_next = {quo[FRAC_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      match_threshold <= '0;
      model_fill      <= '0;
      image_fill      <= '0;
      overflow_seen   <= 1'b0;
      iss_v           <= 1'b0;
      sq_v            <= 1'b0;
      done            <= 1'b0;
    end else begin
      done <= 1'b0;
      sq_v <= iss_v;
      iss_v <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        match_threshold <= cfg_data;
      end
      if (iss_v) begin
        sq_x <= ax * ax;
        sq_y <= ay * ay;
      end
      if (sq_v && (dsq <= DW'(limit))) begin
        hit <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd.action)
              ACT_CLEAR: begin
                model_fill    <= '0;
                image_fill    <= '0;
                overflow_seen <= 1'b0;
              end
              ACT_ADD_MODEL: begin
                if (model_we) begin
                  model_fill <= model_fill + MFW'(1);
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
              ACT_ADD_IMAGE: begin
                if (image_we) begin
                  image_fill <= image_fill + IFW'(1);
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
              ACT_EVALUATE: begin
                limit <= match_threshold * match_threshold;
                if ((model_fill == '0) || (image_fill == '0)) begin
                  done                  <= 1'b1;
                  result.match_count    <= '0;
                  result.model_size     <= '0;
                  result.match_fraction <= '0;
                  result.points_dropped <= overflow_seen;
                end else begin
                  mi    <= '0;
                  count <= '0;
                  state <= S_MREAD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MREAD: begin
          ij    <= '0;
          state <= S_MLATCH;
        end
        S_MLATCH: begin
          mx    <= model_rdata[2*C-1:C];
          my    <= model_rdata[C-1:0];
          hit   <= 1'b0;
          iss_v <= 1'b1;
          ij    <= ij + IFW'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (ij < image_fill) begin
            iss_v <= 1'b1;
            ij    <= ij + IFW'(1);
          end else if (!iss_v && !sq_v) begin
            count <= count_next;
            mi    <= mi_next;
            if (mi_next == model_fill) begin
              rem     <= {1'b0, count_next};
              quo     <= '0;
              div_cnt <= DIV_STEPS;
              state   <= S_DIV;
            end else begin
              state <= S_MREAD;
            end
          end
        end
        S_DIV: begin
          rem     <= rem_next;
          quo     <= quo_next;
          div_cnt <= div_cnt - DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(1)) begin
            done                  <= 1'b1;
            result.match_count    <= CNT_OUT_W'(count);
            result.model_size     <= CNT_OUT_W'(model_fill);
            result.match_fraction <= quo_next;
            result.points_dropped <= overflow_seen;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_ram_write_idle: assert property (@(posedge clk) disable iff (rst)
    (model_we || image_we) |-> !busy)
    else $error("point RAM written during evaluation");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    (model_fill <= MODEL_CAP) && (image_fill <= IMAGE_CAP))
    else $error("fill count beyond capacity");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (count <= model_fill) && (mi <= model_fill))
    else $error("match count or model index beyond model size");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("evaluation began without a command transfer");

endmodule
